>>> src/smt_pkg.sv
package smt_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int VALUE_W          = 32;
   localparam int COUNT_W          = 7;
   localparam int QUEUE_DEPTH      = 2;

   // command codes on the request word
   localparam logic [1:0] CMD_INSERT      = 2'd0;
   localparam logic [1:0] CMD_REMOVE      = 2'd1;
   localparam logic [1:0] CMD_REMOVE_EVEN = 2'd2;

   typedef enum logic [1:0] {
      OP_INSERT,
      OP_REMOVE,
      OP_PURGE_EVEN,
      OP_NONE
   } op_type;

   typedef struct packed {
      logic [1:0]                cmd;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                      ok;
      logic                      is_empty;
      logic signed [VALUE_W-1:0] min_value;
      logic signed [VALUE_W-1:0] max_value;
      logic [COUNT_W-1:0]        count;
   } rsp_type;

   // classified command as it waits in the queue
   typedef struct packed {
      op_type                    op;
      logic signed [VALUE_W-1:0] value;
   } work_type;

endpackage

>>> src/smt_front.sv
module smt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  smt_pkg::req_type req_data,
   output logic             q_valid,
   output smt_pkg::work_type q_word,
   input  logic             q_pop
);
   import smt_pkg::*;

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   work_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              push;
   logic              pop;
   work_type          classified;

   // decode the command into an operation
   always_comb begin
      classified.value = req_data.value;
      case (req_data.cmd)
         CMD_INSERT:      classified.op = OP_INSERT;
         CMD_REMOVE:      classified.op = OP_REMOVE;
         CMD_REMOVE_EVEN: classified.op = OP_PURGE_EVEN;
         default:         classified.op = OP_NONE;
      endcase
   end

   assign busy    = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign push    = start && !busy;
   assign q_valid = (fill_ff != '0);
   assign pop     = q_pop && q_valid;
   assign q_word  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

>>> src/smt_back.sv
module smt_back #(
   parameter int CAPACITY = smt_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  smt_pkg::work_type q_word,
   output logic              q_pop,
   output logic              rsp_strobe,
   output smt_pkg::rsp_type  rsp_data
);
   import smt_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_COMPACT,
      ST_REPORT
   } state_type;

   state_type                 state_ff;
   state_type                 state_in;
   op_type                    op_ff;
   op_type                    op_in;
   logic signed [VALUE_W-1:0] val_ff;
   logic signed [VALUE_W-1:0] val_in;
   logic                      ok_ff;
   logic                      ok_in;
   logic [CAPACITY-1:0]       lt_ff;
   logic [CAPACITY-1:0]       lt_in;
   logic [CAPACITY-1:0]       hit_ff;
   logic [CAPACITY-1:0]       hit_in;
   logic signed [VALUE_W-1:0] cell_ff [CAPACITY];
   logic signed [VALUE_W-1:0] cell_in [CAPACITY];
   logic [CAPACITY-1:0]       occ_ff;
   logic [CAPACITY-1:0]       occ_in;
   rsp_type                   rsp_ff;
   rsp_type                   rsp_in;
   logic                      strobe_ff;
   logic                      strobe_in;

   logic [CAPACITY-1:0]       lt_new;
   logic [CAPACITY-1:0]       hit_new;
   logic [CAPACITY-1:0]       lt_prev;
   logic [CAPACITY-1:0]       gap;
   logic [CAPACITY-1:0]       gap_dn;
   logic [CAPACITY-1:0]       top;
   logic signed [VALUE_W-1:0] max_sel;
   logic [CNT_W-1:0]          cnt_sel;
   logic                      load;

   // per-cell compare of the queue head against the stored values
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         lt_new[i] = occ_ff[i] && (cell_ff[i] < q_word.value);
      end
      for (int i = 0; i < CAPACITY; i++) begin
         hit_new[i] = occ_ff[i] && !lt_new[i] && (cell_ff[i] == q_word.value);
      end
      // only the first cell at or above the value can match
      hit_new[CAPACITY-1:1] = hit_new[CAPACITY-1:1] & lt_new[CAPACITY-2:0];
   end

   assign lt_prev = {lt_ff[CAPACITY-2:0], 1'b1};
   assign gap     = ~occ_ff & {1'b0, occ_ff[CAPACITY-1:1]};
   assign gap_dn  = {gap[CAPACITY-2:0], 1'b0};
   assign top     = occ_ff & ~{1'b0, occ_ff[CAPACITY-1:1]};

   // top of the occupied prefix gives max and count
   always_comb begin
      max_sel = '0;
      cnt_sel = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (top[i]) begin
            max_sel = max_sel | cell_ff[i];
            cnt_sel = cnt_sel | CNT_W'(i + 1);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      val_in    = val_ff;
      ok_in     = ok_ff;
      lt_in     = lt_ff;
      hit_in    = hit_ff;
      cell_in   = cell_ff;
      occ_in    = occ_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      load      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            load = q_valid;
         end
         ST_APPLY: begin
            state_in = ST_REPORT;
            case (op_ff)
               OP_INSERT: begin
                  ok_in = !occ_ff[CAPACITY-1];
                  if (!occ_ff[CAPACITY-1]) begin
                     for (int i = 0; i < CAPACITY; i++) begin
                        if (!lt_ff[i] && lt_prev[i]) begin
                           cell_in[i] = val_ff;
                           occ_in[i]  = 1'b1;
                        end
                     end
                     for (int i = 1; i < CAPACITY; i++) begin
                        if (!lt_ff[i] && !lt_prev[i]) begin
                           cell_in[i] = cell_ff[i-1];
                           occ_in[i]  = occ_ff[i-1];
                        end
                     end
                  end
               end
               OP_REMOVE: begin
                  ok_in = |hit_ff;
                  if (|hit_ff) begin
                     for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (!lt_ff[i]) begin
                           cell_in[i] = cell_ff[i+1];
                           occ_in[i]  = occ_ff[i+1];
                        end
                     end
                     if (!lt_ff[CAPACITY-1]) begin
                        occ_in[CAPACITY-1] = 1'b0;
                     end
                  end
               end
               OP_PURGE_EVEN: begin
                  ok_in = occ_ff[0];
                  if (occ_ff[0]) begin
                     // even values become holes, squeezed out afterwards
                     for (int i = 0; i < CAPACITY; i++) begin
                        occ_in[i] = occ_ff[i] & cell_ff[i][0];
                     end
                     state_in = ST_COMPACT;
                  end
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
         end
         ST_COMPACT: begin
            // each value sitting directly above a hole drops one slot per cycle
            if (|gap) begin
               for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (gap[i]) begin
                     cell_in[i] = cell_ff[i+1];
                  end
               end
               occ_in = (occ_ff | gap) & ~gap_dn;
            end else begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            strobe_in        = 1'b1;
            rsp_in.ok        = ok_ff;
            rsp_in.is_empty  = !occ_ff[0];
            rsp_in.min_value = occ_ff[0] ? cell_ff[0] : '0;
            rsp_in.max_value = max_sel;
            rsp_in.count     = COUNT_W'(cnt_sel);
            load             = q_valid;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         op_in    = q_word.op;
         val_in   = q_word.value;
         lt_in    = lt_new;
         hit_in   = hit_new;
         state_in = ST_APPLY;
      end
   end

   assign q_pop      = load;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      val_ff  <= val_in;
      ok_ff   <= ok_in;
      lt_ff   <= lt_in;
      hit_ff  <= hit_in;
      cell_ff <= cell_in;
      rsp_ff  <= rsp_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         occ_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         occ_ff    <= occ_in;
         strobe_ff <= strobe_in;
      end
   end

endmodule

>>> src/sorted_multiset_table_unit.sv
// flow: a word is queued by the front, loaded by the back, applied, then reported
// insert, remove and unused commands: the back loads the next queued word in the report state
// remove-even on a non-empty set: after apply, the compact state shifts values down past
//    removed entries until no hole is left, then the result is reported
// reset: synchronous, clears queue, occupancy and strobe; no clearing pass
// rsp_strobe is never stalled: it is high for exactly one cycle per result
module sorted_multiset_table_unit #(
   parameter int CAPACITY = smt_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  smt_pkg::req_type req_data,
   output logic             rsp_strobe,
   output smt_pkg::rsp_type rsp_data
);
   import smt_pkg::*;

   // classified words waiting for the cell row
   work_type q_word;
   logic     q_valid;
   logic     q_pop;

   // front: takes a word when the queue has room and decodes the command
   smt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_word   (q_word),
      .q_pop    (q_pop)
   );

   // back: row of sorted cells with occupancy bits
   //    insert shifts the cells above the slot up by one
   //    remove shifts the cells from the match down by one
   //    remove-even punches holes, then the compact state squeezes them out
   //    min is cell 0, max and count come from the top of the occupied prefix
   smt_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_word     (q_word),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
